[hdl/rgb_terrain_classifier_assert.svh]
// assertion macros shared by the classifier modules
`ifndef RGB_TERRAIN_CLASSIFIER_ASSERT_SVH
`define RGB_TERRAIN_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rtc_pkg.sv]
package rtc_pkg;

	// pixel channel and sums
	typedef logic [7:0] chan_t;
	typedef logic [9:0] sum_t;
	typedef logic [15:0] prod_t;
	typedef logic [3:0] cls_t;
	typedef logic [2:0] reg_idx_t;

	// register indexes
	localparam reg_idx_t REG_DEEP_OCEAN   = 3'd0;
	localparam reg_idx_t REG_OCEAN        = 3'd1;
	localparam reg_idx_t REG_COASTAL_MAX  = 3'd2;
	localparam reg_idx_t REG_DESERT       = 3'd3;
	localparam reg_idx_t REG_MOUNTAIN_MIN = 3'd4;
	localparam reg_idx_t REG_MOUNTAIN_MAX = 3'd5;
	localparam reg_idx_t REG_SNOW_BRIGHT  = 3'd6;
	localparam reg_idx_t REG_SNOW_DARK    = 3'd7;

	// terrain class codes
	localparam cls_t CLS_GRASS        = 4'd0;
	localparam cls_t CLS_SNOW         = 4'd1;
	localparam cls_t CLS_DEEP_OCEAN   = 4'd2;
	localparam cls_t CLS_OCEAN        = 4'd3;
	localparam cls_t CLS_SHALLOW      = 4'd4;
	localparam cls_t CLS_DESERT       = 4'd5;
	localparam cls_t CLS_LIGHT_DESERT = 4'd6;
	localparam cls_t CLS_FOREST       = 4'd7;
	localparam cls_t CLS_DARK_FOREST  = 4'd8;
	localparam cls_t CLS_MOUNTAIN     = 4'd9;

	// fixed sum limits for the light desert and dark forest splits
	localparam sum_t LIGHT_DESERT_SUM = 10'd540;
	localparam sum_t DARK_FOREST_SUM  = 10'd210;

	// register reset values
	localparam chan_t RST_DEEP_OCEAN   = 8'd30;
	localparam chan_t RST_OCEAN        = 8'd100;
	localparam chan_t RST_COASTAL_MAX  = 8'd160;
	localparam chan_t RST_DESERT       = 8'd140;
	localparam chan_t RST_MOUNTAIN_MIN = 8'd80;
	localparam chan_t RST_MOUNTAIN_MAX = 8'd180;
	localparam chan_t RST_SNOW_BRIGHT  = 8'd140;
	localparam chan_t RST_SNOW_DARK    = 8'd130;

	typedef struct packed {
		chan_t deep_ocean_level;
		chan_t ocean_level;
		chan_t coastal_max_level;
		chan_t desert_level;
		chan_t mountain_min_level;
		chan_t mountain_max_level;
		chan_t snow_bright_level;
		chan_t snow_dark_level;
	} cfg_t;

	// intensity level to sum scale: 3 * level, fits 10 bits
	function automatic sum_t lvl3(input chan_t lvl);
		return sum_t'({2'b00, lvl}) * sum_t'(3);
	endfunction

endpackage

[hdl/rtc_if.sv]
// pixel word channel
interface rtc_pix_if import rtc_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;
	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// terrain class word channel
interface rtc_cls_if import rtc_pkg::*; ();
	logic valid;
	logic ready;
	cls_t terrain_class;
	modport source (output valid, output terrain_class, input ready);
	modport sink (input valid, input terrain_class, output ready);
endinterface

// register write channel
interface rtc_cfg_if import rtc_pkg::*; ();
	logic     valid;
	logic     ready;
	reg_idx_t index;
	chan_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/rtc_cfg_regs.sv]
`include "rgb_terrain_classifier_assert.svh"

module rtc_cfg_regs import rtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rtc_cfg_if.sink    cfg,
	output cfg_t       levels
);

	cfg_t levels_q;

	// writes are always taken
	assign cfg.ready = 1'b1;
	assign levels = levels_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q.deep_ocean_level   <= RST_DEEP_OCEAN;
			levels_q.ocean_level        <= RST_OCEAN;
			levels_q.coastal_max_level  <= RST_COASTAL_MAX;
			levels_q.desert_level       <= RST_DESERT;
			levels_q.mountain_min_level <= RST_MOUNTAIN_MIN;
			levels_q.mountain_max_level <= RST_MOUNTAIN_MAX;
			levels_q.snow_bright_level  <= RST_SNOW_BRIGHT;
			levels_q.snow_dark_level    <= RST_SNOW_DARK;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DEEP_OCEAN:   levels_q.deep_ocean_level   <= cfg.data;
				REG_OCEAN:        levels_q.ocean_level        <= cfg.data;
				REG_COASTAL_MAX:  levels_q.coastal_max_level  <= cfg.data;
				REG_DESERT:       levels_q.desert_level       <= cfg.data;
				REG_MOUNTAIN_MIN: levels_q.mountain_min_level <= cfg.data;
				REG_MOUNTAIN_MAX: levels_q.mountain_max_level <= cfg.data;
				REG_SNOW_BRIGHT:  levels_q.snow_bright_level  <= cfg.data;
				REG_SNOW_DARK:    levels_q.snow_dark_level    <= cfg.data;
				default: ;
			endcase
		end
	end

	// a write to the deep ocean register lands there; without such a write it holds
	`RTC_ASSERT_NEXT(a_deep_write, clk, arst_n, cfg.valid && cfg.ready && cfg.index == REG_DEEP_OCEAN, levels_q.deep_ocean_level == $past(cfg.data), "deep ocean level not written")
	`RTC_ASSERT_NEXT(a_deep_hold, clk, arst_n, !(cfg.valid && cfg.ready && cfg.index == REG_DEEP_OCEAN), $stable(levels_q.deep_ocean_level), "deep ocean level changed without write")

endmodule

[hdl/rtc_classify.sv]
module rtc_classify import rtc_pkg::*; (
	input  chan_t red,
	input  chan_t green,
	input  chan_t blue,
	input  cfg_t  levels,
	output cls_t  terrain_class
);

	sum_t  s;
	prod_t r16, g16, b16, t16;
	prod_t drg, drb;
	logic  bal_snow, bal_coast;
	logic  snow_hi_ok, snow_lo_ok, is_snow;
	logic  water_deep, water_coast, water_hit, water_is_deep;
	logic  desert_hit, forest_hit, mount_hit;

	// channel sum and denominator
	always_comb begin
		s   = sum_t'(red) + sum_t'(green) + sum_t'(blue);
		r16 = prod_t'(red);
		g16 = prod_t'(green);
		b16 = prod_t'(blue);
		t16 = prod_t'(s) + prod_t'(1);
		drg = (red > green) ? prod_t'(red - green) : prod_t'(green - red);
		drb = (red > blue) ? prod_t'(red - blue) : prod_t'(blue - red);
	end

	// balance tests
	assign bal_snow  = (drg * prod_t'(10) < t16) && (drb * prod_t'(10) < t16);
	assign bal_coast = (drg * prod_t'(100) < t16 * prod_t'(15)) &&
		(drb * prod_t'(100) < t16 * prod_t'(15));

	// snow
	assign snow_hi_ok = (s > lvl3(levels.snow_bright_level)) &&
		(r16 * prod_t'(10) > t16 * prod_t'(3)) &&
		(g16 * prod_t'(10) > t16 * prod_t'(3)) &&
		(b16 * prod_t'(10) > t16 * prod_t'(3));
	assign snow_lo_ok = (s > lvl3(levels.snow_dark_level)) &&
		(r16 * prod_t'(100) > t16 * prod_t'(31)) &&
		(g16 * prod_t'(100) > t16 * prod_t'(31)) &&
		(b16 * prod_t'(100) > t16 * prod_t'(31));
	assign is_snow = bal_snow && (snow_hi_ok || snow_lo_ok);

	// water and its depth
	assign water_deep = (b16 * prod_t'(5) > t16 * prod_t'(2)) &&
		(b16 * prod_t'(2) > r16 * prod_t'(3)) &&
		(b16 * prod_t'(2) > g16 * prod_t'(3));
	assign water_coast = (b16 * prod_t'(4) > t16) && (blue > red) && (blue > green) &&
		(s < lvl3(levels.coastal_max_level)) && bal_coast;
	assign water_hit = water_deep || water_coast;
	assign water_is_deep = (s < lvl3(levels.deep_ocean_level)) ||
		(b16 * prod_t'(25) > t16 * prod_t'(12));

	// desert
	assign desert_hit = (s > lvl3(levels.desert_level)) &&
		(r16 * prod_t'(10) > t16) &&
		(g16 * prod_t'(25) > t16 * prod_t'(7)) &&
		(b16 * prod_t'(10) < t16 * prod_t'(3));

	// forest
	assign forest_hit = (g16 * prod_t'(50) > t16 * prod_t'(19)) &&
		(g16 * prod_t'(5) > r16 * prod_t'(6)) &&
		(g16 * prod_t'(5) > b16 * prod_t'(6));

	// mountain
	assign mount_hit = (r16 * prod_t'(10) > t16 * prod_t'(3)) &&
		(r16 * prod_t'(10) > g16 * prod_t'(11)) &&
		(r16 * prod_t'(5) > b16 * prod_t'(6)) &&
		(g16 * prod_t'(10) > t16) &&
		(b16 * prod_t'(2) < t16) &&
		(s > lvl3(levels.mountain_min_level)) &&
		(s < lvl3(levels.mountain_max_level));

	// priority chain, grassland by default
	always_comb begin
		priority if (is_snow) begin
			terrain_class = CLS_SNOW;
		end else if (water_hit) begin
			if (water_is_deep) begin
				terrain_class = CLS_DEEP_OCEAN;
			end else if (s < lvl3(levels.ocean_level)) begin
				terrain_class = CLS_OCEAN;
			end else begin
				terrain_class = CLS_SHALLOW;
			end
		end else if (desert_hit) begin
			terrain_class = (s > LIGHT_DESERT_SUM) ? CLS_LIGHT_DESERT : CLS_DESERT;
		end else if (forest_hit) begin
			terrain_class = (s < DARK_FOREST_SUM) ? CLS_DARK_FOREST : CLS_FOREST;
		end else if (mount_hit) begin
			terrain_class = CLS_MOUNTAIN;
		end else begin
			terrain_class = CLS_GRASS;
		end
	end

endmodule

[hdl/rgb_terrain_classifier.sv]
// channel   dir  role     word
// pixel     in   sink     red, green, blue (8 bits each)
// terrain   out  source   terrain_class (4 bits)
// cfg       in   sink     index (3 bits), data (8 bits), always ready
//
// one pixel per clock unless the output stalls; the class word is carried through
// the input register, classification logic and result register
// arst_n clears both valid bits and loads the level registers with defaults
// a stalled result holds; pixel.ready drops only when both stages are full
// and terrain.ready is low

`include "rgb_terrain_classifier_assert.svh"

module rgb_terrain_classifier import rtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rtc_pix_if.sink    pixel,
	rtc_cls_if.source  terrain,
	rtc_cfg_if.sink    cfg
);

	logic  v_s1, v_s2;
	chan_t red_s1, green_s1, blue_s1;
	cls_t  cls_s2;
	cls_t  cls_comb;
	cfg_t  levels;
	logic  s1_ready;

	rtc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.levels (levels)
	);

	rtc_classify u_classify (
		.red           (red_s1),
		.green         (green_s1),
		.blue          (blue_s1),
		.levels        (levels),
		.terrain_class (cls_comb)
	);

	// stage handshakes
	assign s1_ready    = !v_s2 || terrain.ready;
	assign pixel.ready = !v_s1 || s1_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pixel.ready) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			red_s1   <= pixel.red;
			green_s1 <= pixel.green;
			blue_s1  <= pixel.blue;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_ready) begin
			cls_s2 <= cls_comb;
		end
	end

	assign terrain.valid         = v_s2;
	assign terrain.terrain_class = cls_s2;

	`RTC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, pixel.valid && pixel.ready, v_s1, "accepted word lost at input register")
	`RTC_ASSERT_NEXT(a_s1_moves_on, clk, arst_n, v_s1 && s1_ready, v_s2 && cls_s2 == $past(cls_comb), "input stage word not carried to result register")
	`RTC_ASSERT_SAME(a_class_range, clk, arst_n, v_s2, cls_s2 <= CLS_MOUNTAIN, "class code out of range")
	`RTC_ASSERT_SAME(a_no_block_when_free, clk, arst_n, terrain.ready, pixel.ready, "input stalled while output side is free")

endmodule

[test/rgb_terrain_classifier_test.sv]
`timescale 1ns / 100ps

module rgb_terrain_classifier_test;
	import rtc_pkg::*;

	localparam int BLOCKS          = 13;
	localparam int PIXELS_PER_BLOCK = 150;
	localparam int QUIET_LIMIT     = 3000;
	localparam int HOLD_CYCLES     = 300;
	localparam int PRESSURE_BLOCK  = 9;
	localparam int DRAIN_CYCLES    = 6;

	// one expected terrain word, with the pixel that caused it
	typedef struct {
		chan_t red;
		chan_t green;
		chan_t blue;
		cls_t  terrain_class;
	} terrain_expect_t;

	// directed pixel row: expected class typed in when known is set
	typedef struct {
		chan_t red;
		chan_t green;
		chan_t blue;
		bit    known;
		cls_t  terrain_class;
	} pixel_row_t;

	logic clk;
	logic arst_n;

	rtc_pix_if pixel_bus ();
	rtc_cls_if terrain_bus ();
	rtc_cfg_if cfg_bus ();

	rgb_terrain_classifier DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel_bus),
		.terrain (terrain_bus),
		.cfg     (cfg_bus)
	);

	cfg_t            levels;
	terrain_expect_t pending_terrain [$];
	terrain_expect_t oldest;
	pixel_row_t      directed_rows [16];

	int send_gap_pct;
	int recv_stall_pct;
	bit hold_request;
	int hold_left;
	int quiet_cycles;
	int mismatches;
	int words_checked;
	int pixels_sent;
	int level_writes;
	int settings_used;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned absdiff(int unsigned a, int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	// red within num/den of the sum plus one against green and blue
	function automatic bit is_balanced(int unsigned r, int unsigned g, int unsigned b,
			int unsigned t, int unsigned num, int unsigned den);
		return den * absdiff(r, g) < num * t && den * absdiff(r, b) < num * t;
	endfunction

	// terrain class of one pixel under the current levels
	function automatic cls_t classify_pixel(chan_t rc, chan_t gc, chan_t bc);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		int unsigned s;
		int unsigned t;
		bit          bright;
		bit          dark;
		bit          open_water;
		bit          coastal;
		r = rc;
		g = gc;
		b = bc;
		s = r + g + b;
		t = s + 1;
		bright = s > 3 * int'(levels.snow_bright_level) &&
			10 * r > 3 * t && 10 * g > 3 * t && 10 * b > 3 * t;
		dark = s > 3 * int'(levels.snow_dark_level) &&
			100 * r > 31 * t && 100 * g > 31 * t && 100 * b > 31 * t;
		open_water = 5 * b > 2 * t && 2 * b > 3 * r && 2 * b > 3 * g;
		coastal = 4 * b > t && b > r && b > g &&
			s < 3 * int'(levels.coastal_max_level) && is_balanced(r, g, b, t, 15, 100);
		if (is_balanced(r, g, b, t, 1, 10) && (bright || dark)) begin
			return CLS_SNOW;
		end else if (open_water || coastal) begin
			if (s < 3 * int'(levels.deep_ocean_level) || 25 * b > 12 * t) begin
				return CLS_DEEP_OCEAN;
			end else if (s < 3 * int'(levels.ocean_level)) begin
				return CLS_OCEAN;
			end else begin
				return CLS_SHALLOW;
			end
		end else if (s > 3 * int'(levels.desert_level) && 10 * r > t &&
				25 * g > 7 * t && 10 * b < 3 * t) begin
			return (s > int'(LIGHT_DESERT_SUM)) ? CLS_LIGHT_DESERT : CLS_DESERT;
		end else if (50 * g > 19 * t && 5 * g > 6 * r && 5 * g > 6 * b) begin
			return (s < int'(DARK_FOREST_SUM)) ? CLS_DARK_FOREST : CLS_FOREST;
		end else if (10 * r > 3 * t && 10 * r > 11 * g && 5 * r > 6 * b &&
				10 * g > t && 2 * b < t &&
				s > 3 * int'(levels.mountain_min_level) &&
				s < 3 * int'(levels.mountain_max_level)) begin
			return CLS_MOUNTAIN;
		end
		return CLS_GRASS;
	endfunction

	function automatic chan_t clamp_chan(int v);
		if (v < 0) begin
			return 8'd0;
		end else if (v > 255) begin
			return 8'd255;
		end
		return chan_t'(v);
	endfunction

	// level near its default, or anywhere
	function automatic chan_t pick_level(chan_t def, bit near);
		if (near) begin
			return clamp_chan(int'(def) + int'($urandom_range(80)) - 40);
		end
		return chan_t'($urandom_range(255));
	endfunction

	// random pixel, mostly shaped toward one terrain family
	task automatic gen_pixel(output chan_t r, output chan_t g, output chan_t b);
		int base;
		case ($urandom_range(5))
			0: begin
				r = chan_t'($urandom);
				g = chan_t'($urandom);
				b = chan_t'($urandom);
			end
			1: begin
				base = $urandom_range(255);
				r = clamp_chan(base + int'($urandom_range(24)) - 12);
				g = clamp_chan(base + int'($urandom_range(24)) - 12);
				b = clamp_chan(base + int'($urandom_range(24)) - 12);
			end
			2: begin
				b = chan_t'($urandom_range(255, 40));
				r = chan_t'($urandom_range(b));
				g = chan_t'($urandom_range(b));
			end
			3: begin
				g = chan_t'($urandom_range(255, 30));
				r = chan_t'($urandom_range(g));
				b = chan_t'($urandom_range(g));
			end
			4: begin
				r = chan_t'($urandom_range(255, 40));
				g = chan_t'($urandom_range(r));
				b = chan_t'($urandom_range(g));
			end
			default: begin
				r = chan_t'($urandom_range(255, 100));
				g = chan_t'($urandom_range(255, 100));
				b = chan_t'($urandom_range(90));
			end
		endcase
	endtask

	// offer one pixel word and record its expected class at accept
	task automatic send_pixel(chan_t r, chan_t g, chan_t b, bit known, cls_t typed_cls);
		terrain_expect_t want;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			pixel_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pixel_bus.valid <= 1'b1;
		pixel_bus.red   <= r;
		pixel_bus.green <= g;
		pixel_bus.blue  <= b;
		do
			@(posedge clk);
		while (!pixel_bus.ready);
		want.red   = r;
		want.green = g;
		want.blue  = b;
		want.terrain_class = known ? typed_cls : classify_pixel(r, g, b);
		pending_terrain.push_back(want);
		pixels_sent++;
	endtask

	// write one level register, leaving valid high for the next word
	task automatic write_level(reg_idx_t idx, chan_t val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		case (idx)
			REG_DEEP_OCEAN:   levels.deep_ocean_level   = val;
			REG_OCEAN:        levels.ocean_level        = val;
			REG_COASTAL_MAX:  levels.coastal_max_level  = val;
			REG_DESERT:       levels.desert_level       = val;
			REG_MOUNTAIN_MIN: levels.mountain_min_level = val;
			REG_MOUNTAIN_MAX: levels.mountain_max_level = val;
			REG_SNOW_BRIGHT:  levels.snow_bright_level  = val;
			REG_SNOW_DARK:    levels.snow_dark_level    = val;
			default: ;
		endcase
		level_writes++;
	endtask

	task automatic load_levels(cfg_t lv);
		write_level(REG_DEEP_OCEAN, lv.deep_ocean_level);
		write_level(REG_OCEAN, lv.ocean_level);
		write_level(REG_COASTAL_MAX, lv.coastal_max_level);
		write_level(REG_DESERT, lv.desert_level);
		write_level(REG_MOUNTAIN_MIN, lv.mountain_min_level);
		write_level(REG_MOUNTAIN_MAX, lv.mountain_max_level);
		write_level(REG_SNOW_BRIGHT, lv.snow_bright_level);
		write_level(REG_SNOW_DARK, lv.snow_dark_level);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		settings_used++;
	endtask

	// stop offering pixels and wait until every class word is back
	task automatic settle();
		@(negedge clk);
		pixel_bus.valid <= 1'b0;
		while (pending_terrain.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver ready, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			terrain_bus.ready <= 1'b0;
			hold_left--;
		end else begin
			terrain_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each terrain word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && terrain_bus.valid && terrain_bus.ready) begin
			if (pending_terrain.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected terrain word: expected none, actual %0d",
					$time, terrain_bus.terrain_class);
			end else begin
				oldest = pending_terrain.pop_front();
				words_checked++;
				if (terrain_bus.terrain_class !== oldest.terrain_class) begin
					mismatches++;
					$display("%0t: terrain_class for rgb (%0d,%0d,%0d): expected %0d, actual %0d",
						$time, oldest.red, oldest.green, oldest.blue,
						oldest.terrain_class, terrain_bus.terrain_class);
				end
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((pixel_bus.valid && pixel_bus.ready) || (terrain_bus.valid && terrain_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("rgb_terrain_classifier verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		chan_t r;
		chan_t g;
		chan_t b;
		cfg_t  lv;
		int    blk;
		int    row;
		arst_n = 1'b0;
		pixel_bus.valid = 1'b0;
		pixel_bus.red = '0;
		pixel_bus.green = '0;
		pixel_bus.blue = '0;
		terrain_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_DEEP_OCEAN;
		cfg_bus.data = '0;
		hold_request = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		mismatches = 0;
		words_checked = 0;
		pixels_sent = 0;
		level_writes = 0;
		settings_used = 1;
		send_gap_pct = 30;
		recv_stall_pct = 80;
		levels = '{RST_DEEP_OCEAN, RST_OCEAN, RST_COASTAL_MAX, RST_DESERT,
			RST_MOUNTAIN_MIN, RST_MOUNTAIN_MAX, RST_SNOW_BRIGHT, RST_SNOW_DARK};

		// extremes and one pixel per class under the reset levels
		directed_rows = '{
			'{8'd0,   8'd0,   8'd0,   1'b1, CLS_GRASS},
			'{8'd255, 8'd255, 8'd255, 1'b1, CLS_SNOW},
			'{8'd0,   8'd0,   8'd255, 1'b1, CLS_DEEP_OCEAN},
			'{8'd255, 8'd0,   8'd0,   1'b1, CLS_GRASS},
			'{8'd0,   8'd255, 8'd0,   1'b1, CLS_FOREST},
			'{8'd0,   8'd100, 8'd0,   1'b0, CLS_GRASS},
			'{8'd255, 8'd255, 8'd0,   1'b0, CLS_GRASS},
			'{8'd255, 8'd255, 8'd40,  1'b0, CLS_GRASS},
			'{8'd150, 8'd100, 8'd50,  1'b0, CLS_GRASS},
			'{8'd60,  8'd60,  8'd100, 1'b0, CLS_GRASS},
			'{8'd120, 8'd120, 8'd180, 1'b0, CLS_GRASS},
			'{8'd135, 8'd135, 8'd135, 1'b0, CLS_GRASS},
			'{8'd170, 8'd170, 8'd170, 1'b0, CLS_GRASS},
			'{8'd10,  8'd10,  8'd30,  1'b0, CLS_GRASS},
			'{8'd85,  8'd85,  8'd85,  1'b0, CLS_GRASS},
			'{8'd128, 8'd127, 8'd64,  1'b0, CLS_GRASS}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (row = 0; row < 16; row++) begin
			send_pixel(directed_rows[row].red, directed_rows[row].green,
				directed_rows[row].blue, directed_rows[row].known,
				directed_rows[row].terrain_class);
		end

		// random pixels, one level setting per block
		for (blk = 0; blk < BLOCKS; blk++) begin
			if (blk < 4) begin
				send_gap_pct = 30;
				recv_stall_pct = 80;
			end else if (blk < 8) begin
				send_gap_pct = 80;
				recv_stall_pct = 30;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			settle();
			case (blk)
				1: lv = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
				2: lv = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
				6: lv = '{RST_DEEP_OCEAN, RST_OCEAN, RST_COASTAL_MAX, RST_DESERT,
					RST_MOUNTAIN_MIN, RST_MOUNTAIN_MAX, RST_SNOW_BRIGHT, RST_SNOW_DARK};
				default: begin
					lv.deep_ocean_level   = pick_level(RST_DEEP_OCEAN, blk[0]);
					lv.ocean_level        = pick_level(RST_OCEAN, blk[0]);
					lv.coastal_max_level  = pick_level(RST_COASTAL_MAX, blk[0]);
					lv.desert_level       = pick_level(RST_DESERT, blk[0]);
					lv.mountain_min_level = pick_level(RST_MOUNTAIN_MIN, blk[0]);
					lv.mountain_max_level = pick_level(RST_MOUNTAIN_MAX, blk[0]);
					lv.snow_bright_level  = pick_level(RST_SNOW_BRIGHT, blk[0]);
					lv.snow_dark_level    = pick_level(RST_SNOW_DARK, blk[0]);
				end
			endcase
			load_levels(lv);
			if (blk == PRESSURE_BLOCK) begin
				hold_request = 1'b1;
			end
			repeat (PIXELS_PER_BLOCK) begin
				gen_pixel(r, g, b);
				send_pixel(r, g, b, 1'b0, CLS_GRASS);
			end
		end

		settle();
		$display("run covered %0d pixels (16 directed) over %0d level settings, incl. all-zero, all-max",
			pixels_sent, settings_used);
		$display("%0d register writes, %0d class words checked, %0d mismatches",
			level_writes, words_checked, mismatches);
		if (mismatches == 0) begin
			$display("rgb_terrain_classifier verification clean");
		end else begin
			$display("rgb_terrain_classifier verification failed");
		end
		$finish;
	end

endmodule
